// ----- rtl/rwpe_pkg.sv -----
`timescale 1ns / 1ps

package rwpe_pkg;

   localparam int unsigned DIV_W  = 31;
   localparam int unsigned ROOT_W = 32;
   localparam int unsigned SREM_W = 34;
   localparam logic [31:0] RATIO_MAX = 32'h7FFF_FFFF;
   localparam logic [31:0] RATIO_MIN = 32'h8000_0000;
   localparam logic [30:0] ERR_MAX   = 31'h7FFF_FFFF;

   typedef struct packed {
      logic        valid;
      logic        ratio_ok;
      logic        err_ok;
      logic        rneg;
      logic        last;
      logic [30:0] d;
      logic [31:0] c;
   } side_div_type;

   typedef struct packed {
      logic        valid;
      logic        ratio_ok;
      logic        err_ok;
      logic        last;
      logic        ovf;
      logic        sat;
      logic [31:0] ratio;
      logic [30:0] d;
      logic [30:0] t1;
   } side_mul_type;

   typedef struct packed {
      logic        valid;
      logic        ratio_ok;
      logic        err_ok;
      logic        last;
      logic        ovf;
      logic        sat;
      logic [31:0] ratio;
   } side_out_type;

   // one restoring division step: {quotient bit, new remainder}
   function automatic logic [DIV_W:0] div_step(input logic [DIV_W-1:0] rem,
                                                input logic nbit,
                                                input logic [DIV_W-1:0] d);
      logic [DIV_W:0] trial;
      logic [DIV_W:0] diff;
      trial = {rem, nbit};
      diff  = trial - {1'b0, d};
      if (trial >= {1'b0, d}) begin
         div_step = {1'b1, diff[DIV_W-1:0]};
      end else begin
         div_step = {1'b0, trial[DIV_W-1:0]};
      end
   endfunction

endpackage

// ----- rtl/ratio_with_propagated_error_top.sv -----
`timescale 1ns / 1ps

// Ratio of two signed fixed-point rates and its propagated error. One request enters
// per clock and one response leaves per clock while no stall holds the pipeline. It is
// built from the bit-per-stage dividers (FRAC_BITS + 32 stages for ratio and rate error, 31 for the
// scaled control error) and the 32-stage square root. The whole pipeline advances together
// while the response register is empty or taken, so req_stall follows rsp_stall only when
// a response is waiting.
module ratio_with_propagated_error_top #(
   parameter int FRAC_BITS = 16
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic signed [31:0] req_rate_value,
   input  logic               req_rate_ok,
   input  logic signed [31:0] req_control_value,
   input  logic               req_control_ok,
   input  logic signed [31:0] req_rate_err,
   input  logic               req_rate_err_ok,
   input  logic signed [31:0] req_control_err,
   input  logic               req_control_err_ok,
   input  logic               req_last_position,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic signed [31:0] rsp_ratio,
   output logic               rsp_ratio_ok,
   output logic [30:0]        rsp_ratio_err,
   output logic               rsp_ratio_err_ok,
   output logic               rsp_overflow,
   output logic               rsp_last
);
   import rwpe_pkg::*;

   localparam int QW     = 32 + FRAC_BITS;
   localparam int MSPLIT = 28;
   localparam int QH     = QW - MSPLIT;
   localparam int PW     = QW + 32;

   logic en;

   // input stage
   logic [31:0] rmag, emag, cmag;
   logic        pos;
   side_div_type side0;

   assign rmag = req_rate_value[31] ? (~req_rate_value + 32'd1) : req_rate_value;
   assign emag = req_rate_err[31] ? (~req_rate_err + 32'd1) : req_rate_err;
   assign cmag = req_control_err[31] ? (~req_control_err + 32'd1) : req_control_err;
   assign pos  = req_control_ok && !req_control_value[31] && (req_control_value != 32'd0);

   always_comb begin
      side0.valid    = req_valid;
      side0.ratio_ok = pos && req_rate_ok;
      side0.err_ok   = pos && req_rate_ok && req_rate_err_ok && req_control_err_ok;
      side0.rneg     = req_rate_value[31];
      side0.last     = req_last_position;
      side0.d        = pos ? req_control_value[30:0] : 31'd1;
      side0.c        = cmag;
   end

   // ratio and rate error dividers
   side_div_type     sd_ff [0:QW];
   logic [30:0]      rem_a_ff [0:QW];
   logic [30:0]      rem_b_ff [0:QW];
   logic [QW-1:0]    x_a_ff [0:QW];
   logic [QW-1:0]    x_b_ff [0:QW];

   always_ff @(posedge clock) begin
      if (reset) begin
         sd_ff[0] <= '0;
      end else if (en) begin
         sd_ff[0] <= side0;
      end
      if (en) begin
         rem_a_ff[0] <= '0;
         rem_b_ff[0] <= '0;
         x_a_ff[0]   <= {rmag, {FRAC_BITS{1'b0}}};
         x_b_ff[0]   <= {emag, {FRAC_BITS{1'b0}}};
      end
   end

   for (genvar k = 0; k < QW; k++) begin : g_div_ab
      logic [31:0] step_a_in, step_b_in;
      assign step_a_in = div_step(rem_a_ff[k], x_a_ff[k][QW-1], sd_ff[k].d);
      assign step_b_in = div_step(rem_b_ff[k], x_b_ff[k][QW-1], sd_ff[k].d);
      always_ff @(posedge clock) begin
         if (reset) begin
            sd_ff[k+1] <= '0;
         end else if (en) begin
            sd_ff[k+1] <= sd_ff[k];
         end
         if (en) begin
            rem_a_ff[k+1] <= step_a_in[30:0];
            rem_b_ff[k+1] <= step_b_in[30:0];
            x_a_ff[k+1]   <= {x_a_ff[k][QW-2:0], step_a_in[31]};
            x_b_ff[k+1]   <= {x_b_ff[k][QW-2:0], step_b_in[31]};
         end
      end
   end

   // saturate ratio, split product of quotient and control error
   logic [QW-1:0]    q, t1;
   logic             q_hi, r_over;
   side_div_type     sdq;
   side_mul_type     m1_in, m1_ff, m2_ff, m3_in;
   logic [MSPLIT+31:0] pl_in, pl_ff;
   logic [QH+31:0]     ph_in, ph_ff;
   logic [PW-1:0]      prod_ff;
   logic [QW:0]        prod_hi;

   assign q    = x_a_ff[QW];
   assign t1   = x_b_ff[QW];
   assign sdq  = sd_ff[QW];
   assign q_hi = |q[QW-1:32];
   assign r_over = sdq.rneg ? (q_hi || (q[31] && (|q[30:0]))) : (q_hi || q[31]);

   always_comb begin
      m1_in.valid    = sdq.valid;
      m1_in.ratio_ok = sdq.ratio_ok;
      m1_in.err_ok   = sdq.err_ok;
      m1_in.last     = sdq.last;
      m1_in.ovf      = sdq.ratio_ok && r_over;
      m1_in.sat      = |t1[QW-1:31];
      m1_in.d        = sdq.d;
      m1_in.t1       = t1[30:0];
      if (!sdq.ratio_ok) begin
         m1_in.ratio = '0;
      end else if (sdq.rneg) begin
         m1_in.ratio = r_over ? RATIO_MIN : (~q[31:0] + 32'd1);
      end else begin
         m1_in.ratio = r_over ? RATIO_MAX : q[31:0];
      end
   end

   assign pl_in   = q[MSPLIT-1:0] * sdq.c;
   assign ph_in   = q[QW-1:MSPLIT] * sdq.c;
   assign prod_hi = prod_ff[PW-1:31];

   always_comb begin
      m3_in     = m2_ff;
      m3_in.sat = m2_ff.sat || (prod_hi >= (QW+1)'(m2_ff.d));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         m1_ff <= '0;
         m2_ff <= '0;
      end else if (en) begin
         m1_ff <= m1_in;
         m2_ff <= m1_ff;
      end
      if (en) begin
         pl_ff   <= pl_in;
         ph_ff   <= ph_in;
         prod_ff <= (PW'(ph_ff) << MSPLIT) + PW'(pl_ff);
      end
   end

   // scaled control error divider
   side_mul_type sc_ff [0:DIV_W];
   logic [30:0]  rem_c_ff [0:DIV_W];
   logic [30:0]  x_c_ff [0:DIV_W];

   always_ff @(posedge clock) begin
      if (reset) begin
         sc_ff[0] <= '0;
      end else if (en) begin
         sc_ff[0] <= m3_in;
      end
      if (en) begin
         rem_c_ff[0] <= prod_hi[30:0];
         x_c_ff[0]   <= prod_ff[30:0];
      end
   end

   for (genvar k = 0; k < DIV_W; k++) begin : g_div_c
      logic [31:0] step_c_in;
      assign step_c_in = div_step(rem_c_ff[k], x_c_ff[k][30], sc_ff[k].d);
      always_ff @(posedge clock) begin
         if (reset) begin
            sc_ff[k+1] <= '0;
         end else if (en) begin
            sc_ff[k+1] <= sc_ff[k];
         end
         if (en) begin
            rem_c_ff[k+1] <= step_c_in[30:0];
            x_c_ff[k+1]   <= {x_c_ff[k][29:0], step_c_in[31]};
         end
      end
   end

   // sum of squares
   side_mul_type sce;
   side_out_type s1_in, s1_ff;
   logic [61:0]  t1sq_ff, t2sq_ff;
   logic [62:0]  sum;

   assign sce = sc_ff[DIV_W];
   assign sum = 63'(t1sq_ff) + 63'(t2sq_ff);

   always_comb begin
      s1_in.valid    = sce.valid;
      s1_in.ratio_ok = sce.ratio_ok;
      s1_in.err_ok   = sce.err_ok;
      s1_in.last     = sce.last;
      s1_in.ovf      = sce.ovf;
      s1_in.sat      = sce.sat;
      s1_in.ratio    = sce.ratio;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_ff <= '0;
      end else if (en) begin
         s1_ff <= s1_in;
      end
      if (en) begin
         t1sq_ff <= 62'(sce.t1) * 62'(sce.t1);
         t2sq_ff <= 62'(x_c_ff[DIV_W]) * 62'(x_c_ff[DIV_W]);
      end
   end

   // square root, one result bit per stage
   side_out_type          sq_ff [0:ROOT_W];
   logic [SREM_W-1:0]     srem_ff [0:ROOT_W];
   logic [ROOT_W-1:0]     root_ff [0:ROOT_W];
   logic [2*ROOT_W-1:0]   sx_ff [0:ROOT_W];

   always_ff @(posedge clock) begin
      if (reset) begin
         sq_ff[0] <= '0;
      end else if (en) begin
         sq_ff[0] <= s1_ff;
      end
      if (en) begin
         srem_ff[0] <= '0;
         root_ff[0] <= '0;
         sx_ff[0]   <= {1'b0, sum};
      end
   end

   for (genvar k = 0; k < ROOT_W; k++) begin : g_sqrt
      logic [SREM_W+1:0] cand, trial, diff;
      logic              ge;
      assign cand  = {srem_ff[k], sx_ff[k][2*ROOT_W-1:2*ROOT_W-2]};
      assign trial = (SREM_W+2)'({root_ff[k], 2'b01});
      assign diff  = cand - trial;
      assign ge    = cand >= trial;
      always_ff @(posedge clock) begin
         if (reset) begin
            sq_ff[k+1] <= '0;
         end else if (en) begin
            sq_ff[k+1] <= sq_ff[k];
         end
         if (en) begin
            srem_ff[k+1] <= ge ? diff[SREM_W-1:0] : cand[SREM_W-1:0];
            root_ff[k+1] <= {root_ff[k][ROOT_W-2:0], ge};
            sx_ff[k+1]   <= {sx_ff[k][2*ROOT_W-3:0], 2'b00};
         end
      end
   end

   // response register
   side_out_type      sqe;
   logic              err_sat;
   logic              out_valid_ff, out_ratio_ok_ff, out_err_ok_ff, out_ovf_ff, out_last_ff;
   logic [31:0]       out_ratio_ff;
   logic [30:0]       out_err_ff;

   assign sqe     = sq_ff[ROOT_W];
   assign err_sat = sqe.sat || root_ff[ROOT_W][ROOT_W-1];
   assign en      = !out_valid_ff || !rsp_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (en) begin
         out_valid_ff <= sqe.valid;
      end
      if (en) begin
         out_ratio_ok_ff <= sqe.ratio_ok;
         out_err_ok_ff   <= sqe.err_ok;
         out_last_ff     <= sqe.last;
         out_ratio_ff    <= sqe.ratio;
         out_ovf_ff      <= sqe.ovf || (sqe.err_ok && err_sat);
         if (!sqe.err_ok) begin
            out_err_ff <= '0;
         end else if (err_sat) begin
            out_err_ff <= ERR_MAX;
         end else begin
            out_err_ff <= root_ff[ROOT_W][30:0];
         end
      end
   end

   assign req_stall        = !en;
   assign rsp_valid        = out_valid_ff;
   assign rsp_ratio        = out_ratio_ff;
   assign rsp_ratio_ok     = out_ratio_ok_ff;
   assign rsp_ratio_err    = out_err_ff;
   assign rsp_ratio_err_ok = out_err_ok_ff;
   assign rsp_overflow     = out_ovf_ff;
   assign rsp_last         = out_last_ff;

endmodule
